[rtl/core/siud_pkg.sv]
// Package for the set intersection, union and difference unit.
// Holds the item codes, result status codes, sequencer states and a shared struct.
// No dependencies.
package siud_pkg;

  // Width of one set member.
  localparam int unsigned ValueWidth = 32;

  // Codes of the kind field of an input word.
  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_OP    = 2'd2
  } kind_e;

  // Codes of the operation field.
  typedef enum logic [1:0] {
    OP_AND       = 2'd0,
    OP_OR        = 2'd1,
    OP_A_MINUS_B = 2'd2,
    OP_B_MINUS_A = 2'd3
  } op_e;

  // Status codes of a result word.
  typedef enum logic [2:0] {
    ST_MEMBER       = 3'd0,
    ST_ACCEPTED     = 3'd1,
    ST_DUPLICATE    = 3'd2,
    ST_FULL         = 3'd3,
    ST_EMPTY_RESULT = 3'd4,
    ST_SET_EMPTY    = 3'd5
  } status_e;

  // States of the top-level sequencer.
  typedef enum logic [2:0] {
    S_IDLE,
    S_REPLY,
    S_ADD_SCAN,
    S_OP_READ,
    S_OP_LATCH,
    S_OP_SCAN,
    S_OP_EMIT,
    S_OP_END
  } state_e;

  // Answer of the membership scan unit.
  typedef struct packed {
    logic done;
    logic found;
  } match_rsp_t;

endpackage

[rtl/core/set_intersection_union_difference_unit.sv]
// Top level of the set intersection, union and difference unit: sequencer, counts, output word.
// Depends on siud_pkg, siud_ram and siud_match.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | kind_i, set_select_i, element_value_i,
//           |           |                           | operation_i
//   out     | output    | out_valid_o / out_stall_i | member_value_o, status_o, last_o
//
// A clear goes straight to S_REPLY. An add scans the target set, one compare per cycle,
// then replies. An operation takes each outer member through S_OP_READ, S_OP_LATCH,
// S_OP_SCAN (one compare per inner entry; skipped in the first half of a union) and S_OP_EMIT;
// the single comparator and the one read port of each set store set this pace.
// Reset zeroes both counts; the stores are not cleared and need no sweep.
// A stalled output holds the sequencer only when it has a new word to hand over.
module set_intersection_union_difference_unit import siud_pkg::*; #(
  parameter int unsigned SET_CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic               set_select_i,
  input  logic signed [31:0] element_value_i,
  input  logic [1:0]         operation_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] member_value_o,
  output logic [2:0]         status_o,
  output logic               last_o
);

  localparam int unsigned CntWidth  = $clog2(SET_CAPACITY + 1);
  localparam int unsigned AddrWidth = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam logic [CntWidth-1:0] Capacity = CntWidth'(SET_CAPACITY);

  state_e                state_q, state_d;
  logic [CntWidth-1:0]   cnt_a_q, cnt_a_d;
  logic [CntWidth-1:0]   cnt_b_q, cnt_b_d;
  logic                  tgt_q, tgt_d;     // store that is scanned; the other one is walked
  logic [ValueWidth-1:0] key_q, key_d;
  logic [CntWidth-1:0]   idx_q, idx_d;
  logic                  all_q, all_d;
  logic                  want_q, want_d;
  logic                  union_q, union_d;
  logic                  qual_q, qual_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [ValueWidth-1:0] pend_val_q, pend_val_d;
  status_e               reply_q, reply_d;

  logic                  out_vld_q;
  logic [ValueWidth-1:0] out_val_q;
  status_e               out_sts_q;
  logic                  out_last_q;

  logic                  out_free;
  logic                  push;
  logic [ValueWidth-1:0] push_val;
  status_e               push_sts;
  logic                  push_last;
  logic                  emit_go;

  logic                  wr_en;
  logic                  we_a, we_b;
  logic [AddrWidth-1:0]  raddr_a, raddr_b;
  logic [ValueWidth-1:0] rdata_a, rdata_b;
  logic [ValueWidth-1:0] scan_rdata, walk_rdata;
  logic [CntWidth-1:0]   scan_cnt, walk_cnt;
  logic [AddrWidth-1:0]  scan_addr;
  logic                  scan_start;
  match_rsp_t            mrsp;

  // Store addressing: the scanned store follows the scan unit, the other the walk index.
  assign raddr_a    = tgt_q ? idx_q[AddrWidth-1:0] : scan_addr;
  assign raddr_b    = tgt_q ? scan_addr : idx_q[AddrWidth-1:0];
  assign scan_rdata = tgt_q ? rdata_b : rdata_a;
  assign walk_rdata = tgt_q ? rdata_a : rdata_b;
  assign scan_cnt   = tgt_q ? cnt_b_q : cnt_a_q;
  assign walk_cnt   = tgt_q ? cnt_a_q : cnt_b_q;
  assign we_a       = wr_en && !tgt_q;
  assign we_b       = wr_en && tgt_q;

  siud_ram #(
    .WIDTH (ValueWidth),
    .DEPTH (SET_CAPACITY)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AddrWidth-1:0]),
    .wdata_i (key_q),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  siud_ram #(
    .WIDTH (ValueWidth),
    .DEPTH (SET_CAPACITY)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AddrWidth-1:0]),
    .wdata_i (key_q),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  siud_match #(
    .SET_CAPACITY (SET_CAPACITY)
  ) u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .key_i   (key_q),
    .count_i (scan_cnt),
    .rdata_i (scan_rdata),
    .addr_o  (scan_addr),
    .rsp_o   (mrsp)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer: next state, store updates and the word handed to the output register.
  always_comb begin
    state_d    = state_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    tgt_d      = tgt_q;
    key_d      = key_q;
    idx_d      = idx_q;
    all_d      = all_q;
    want_d     = want_q;
    union_d    = union_q;
    qual_d     = qual_q;
    pend_vld_d = pend_vld_q;
    pend_val_d = pend_val_q;
    reply_d    = reply_q;
    push       = 1'b0;
    push_val   = '0;
    push_sts   = ST_MEMBER;
    push_last  = 1'b0;
    wr_en      = 1'b0;
    scan_start = 1'b0;
    emit_go    = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d = element_value_i;
          tgt_d = set_select_i;
          unique case (kind_e'(kind_i))
            KIND_CLEAR: begin
              if (set_select_i) begin
                cnt_b_d = '0;
              end else begin
                cnt_a_d = '0;
              end
              reply_d = ST_ACCEPTED;
              state_d = S_REPLY;
            end
            KIND_ADD: begin
              scan_start = 1'b1;
              state_d    = S_ADD_SCAN;
            end
            KIND_OP: begin
              if (cnt_a_q == '0 || cnt_b_q == '0) begin
                reply_d = ST_SET_EMPTY;
                state_d = S_REPLY;
              end else begin
                idx_d      = '0;
                pend_vld_d = 1'b0;
                all_d      = 1'b0;
                want_d     = 1'b0;
                union_d    = 1'b0;
                tgt_d      = 1'b1;
                unique case (op_e'(operation_i))
                  OP_AND: want_d = 1'b1;
                  OP_OR: begin
                    all_d   = 1'b1;
                    union_d = 1'b1;
                  end
                  OP_A_MINUS_B: tgt_d = 1'b1;
                  OP_B_MINUS_A: tgt_d = 1'b0;
                  default: tgt_d = 1'b1;
                endcase
                state_d = S_OP_READ;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_REPLY: begin
        if (out_free) begin
          push      = 1'b1;
          push_sts  = reply_q;
          push_last = 1'b1;
          state_d   = S_IDLE;
        end
      end

      // Duplicate check first, then the capacity check, then the write.
      S_ADD_SCAN: begin
        if (mrsp.done) begin
          if (mrsp.found) begin
            reply_d = ST_DUPLICATE;
          end else if (scan_cnt >= Capacity) begin
            reply_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            reply_d = ST_ACCEPTED;
            if (tgt_q) begin
              cnt_b_d = cnt_b_q + CntWidth'(1);
            end else begin
              cnt_a_d = cnt_a_q + CntWidth'(1);
            end
          end
          state_d = S_REPLY;
        end
      end

      S_OP_READ: state_d = S_OP_LATCH;

      // The walked member becomes the key of the scan over the other store.
      S_OP_LATCH: begin
        key_d = walk_rdata;
        if (all_q) begin
          qual_d  = 1'b1;
          state_d = S_OP_EMIT;
        end else begin
          scan_start = 1'b1;
          state_d    = S_OP_SCAN;
        end
      end

      S_OP_SCAN: begin
        if (mrsp.done) begin
          qual_d  = (mrsp.found == want_q);
          state_d = S_OP_EMIT;
        end
      end

      // A qualifying member is held back one step so that the final one can carry last.
      S_OP_EMIT: begin
        if (qual_q && pend_vld_q) begin
          if (out_free) begin
            push     = 1'b1;
            push_val = pend_val_q;
          end else begin
            emit_go = 1'b0;
          end
        end
        if (emit_go) begin
          if (qual_q) begin
            pend_vld_d = 1'b1;
            pend_val_d = key_q;
          end
          if (idx_q + CntWidth'(1) == walk_cnt) begin
            if (union_q) begin
              // Second half of a union: members of B that are not in A.
              union_d = 1'b0;
              all_d   = 1'b0;
              want_d  = 1'b0;
              tgt_d   = 1'b0;
              idx_d   = '0;
              state_d = S_OP_READ;
            end else begin
              state_d = S_OP_END;
            end
          end else begin
            idx_d   = idx_q + CntWidth'(1);
            state_d = S_OP_READ;
          end
        end
      end

      S_OP_END: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (pend_vld_q) begin
            push_val = pend_val_q;
          end else begin
            push_sts = ST_EMPTY_RESULT;
          end
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      tgt_q      <= 1'b0;
      idx_q      <= '0;
      all_q      <= 1'b0;
      want_q     <= 1'b0;
      union_q    <= 1'b0;
      qual_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      reply_q    <= ST_ACCEPTED;
    end else begin
      state_q    <= state_d;
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      tgt_q      <= tgt_d;
      idx_q      <= idx_d;
      all_q      <= all_d;
      want_q     <= want_d;
      union_q    <= union_d;
      qual_q     <= qual_d;
      pend_vld_q <= pend_vld_d;
      reply_q    <= reply_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    pend_val_q <= pend_val_d;
  end

  // Output register: loads a new word when the previous one has gone or is leaving.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_val_q  <= push_val;
      out_sts_q  <= push_sts;
      out_last_q <= push_last;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign member_value_o = out_val_q;
  assign status_o       = out_sts_q;
  assign last_o         = out_last_q;

  // Checks on the sequencer.
  a_cnt_a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_a_q <= Capacity)
    else $error("set A count beyond capacity");

  a_cnt_b_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_b_q <= Capacity)
    else $error("set B count beyond capacity");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_sts_q != ST_MEMBER) |-> out_last_q)
    else $error("non-member word without last");

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mrsp.done |-> (state_q == S_ADD_SCAN || state_q == S_OP_SCAN))
    else $error("scan finished outside a scan state");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_vld_q)
    else $error("member left pending in idle");

endmodule

[rtl/core/siud_ram.sv]
// Generic single-port-write, single-port-read memory with a registered read.
// Used for both set stores; no dependencies.
module siud_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/siud_match.sv]
// Shared membership scan: walks a set store one entry per cycle and compares it with a key.
// Depends on siud_pkg.
module siud_match import siud_pkg::*; #(
  parameter int unsigned SET_CAPACITY = 16
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  start_i,
  input  logic [ValueWidth-1:0]                                 key_i,
  input  logic [$clog2(SET_CAPACITY+1)-1:0]                     count_i,
  input  logic [ValueWidth-1:0]                                 rdata_i,
  output logic [((SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1)-1:0] addr_o,
  output match_rsp_t                                            rsp_o
);

  localparam int unsigned CntWidth  = $clog2(SET_CAPACITY + 1);
  localparam int unsigned AddrWidth = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

  logic                busy_q, busy_d;
  logic                chk_q, chk_d;
  logic [CntWidth-1:0] idx_q, idx_d;
  logic                hit;
  logic                at_end;

  // The entry read last cycle is compared now, while the next address goes out.
  assign hit        = busy_q && chk_q && (rdata_i == key_i);
  assign at_end     = busy_q && (idx_q == count_i);
  assign rsp_o.done  = hit || at_end;
  assign rsp_o.found = hit;
  assign addr_o     = idx_q[AddrWidth-1:0];

  // Scan control.
  always_comb begin
    busy_d = busy_q;
    chk_d  = chk_q;
    idx_d  = idx_q;
    if (start_i) begin
      busy_d = 1'b1;
      chk_d  = 1'b0;
      idx_d  = '0;
    end else if (busy_q) begin
      if (rsp_o.done) begin
        busy_d = 1'b0;
        chk_d  = 1'b0;
      end else begin
        idx_d = idx_q + CntWidth'(1);
        chk_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chk_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      chk_q  <= chk_d;
      idx_q  <= idx_d;
    end
  end

endmodule

[test/tb_set_intersection_union_difference_unit.sv]
// Self-checking testbench for set_intersection_union_difference_unit.
// Depends on siud_pkg and the unit itself. It keeps its own copy of both sets and predicts
// every result word, then checks the output channel against it under random idling.
module tb_set_intersection_union_difference_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import siud_pkg::*;

  localparam int unsigned Capacity = 16;
  localparam logic [1:0] KindUnused = 2'd3;
  localparam int PoolSize = 24;
  localparam int RandomCommands = 420;
  localparam int TailCommands = 50;
  localparam int ReportLimit = 10;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles = 400;

  // One input word and one result word as the testbench sees them.
  typedef struct {
    logic [1:0]  kind;
    logic        sel;
    logic [31:0] value;
    op_e         op;
  } command_t;

  typedef struct {
    logic [31:0] value;
    status_e     status;
    logic        last;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         kind_i = '0;
  logic               set_select_i = 1'b0;
  logic signed [31:0] element_value_i = '0;
  logic [1:0]         operation_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] member_value_o;
  logic [2:0]         status_o;
  logic               last_o;

  // Commands waiting to be driven and result words waiting to be seen.
  command_t command_queue [$];
  result_t  due_results [$];

  // Own copy of both sets: index 0 is set A, index 1 is set B.
  logic [31:0] set_mem [2][Capacity];
  int unsigned set_size [2] = '{0, 0};

  logic [31:0] value_pool [PoolSize];
  int counted_commands = 0;
  int total_commands = 0;
  int accepted_commands = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int in_gap = 0;
  int stall_left = 0;
  bit in_taken = 1'b0;
  bit tail_phase = 1'b0;
  bit in_idle_on = 1'b1;
  bit stall_on = 1'b1;
  command_t next_command;

  set_intersection_union_difference_unit #(
    .SET_CAPACITY(Capacity)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .set_select_i    (set_select_i),
    .element_value_i (element_value_i),
    .operation_i     (operation_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .member_value_o  (member_value_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit set_holds(int s, logic [31:0] v);
    for (int i = 0; i < set_size[s]; i++) begin
      if (set_mem[s][i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void expect_single(status_e st);
    result_t r;
    r.value = '0;
    r.status = st;
    r.last = 1'b1;
    due_results.push_back(r);
  endfunction

  // Updates the set copy for one accepted word and queues the result words it causes.
  function automatic void apply_command(command_t c);
    logic [31:0] picked [$];
    result_t r;
    int s;
    s = int'(c.sel);
    if (c.kind == KIND_CLEAR) begin
      set_size[s] = 0;
      expect_single(ST_ACCEPTED);
    end else if (c.kind == KIND_ADD) begin
      // The duplicate check takes precedence over the full check.
      if (set_holds(s, c.value)) begin
        expect_single(ST_DUPLICATE);
      end else if (set_size[s] >= Capacity) begin
        expect_single(ST_FULL);
      end else begin
        set_mem[s][set_size[s]] = c.value;
        set_size[s]++;
        expect_single(ST_ACCEPTED);
      end
    end else if (c.kind == KIND_OP) begin
      if (set_size[0] == 0 || set_size[1] == 0) begin
        expect_single(ST_SET_EMPTY);
      end else begin
        case (c.op)
          OP_AND: begin
            for (int i = 0; i < set_size[0]; i++) begin
              if (set_holds(1, set_mem[0][i])) picked.push_back(set_mem[0][i]);
            end
          end
          OP_OR: begin
            for (int i = 0; i < set_size[0]; i++) picked.push_back(set_mem[0][i]);
            for (int i = 0; i < set_size[1]; i++) begin
              if (!set_holds(0, set_mem[1][i])) picked.push_back(set_mem[1][i]);
            end
          end
          OP_A_MINUS_B: begin
            for (int i = 0; i < set_size[0]; i++) begin
              if (!set_holds(1, set_mem[0][i])) picked.push_back(set_mem[0][i]);
            end
          end
          default: begin
            for (int i = 0; i < set_size[1]; i++) begin
              if (!set_holds(0, set_mem[1][i])) picked.push_back(set_mem[1][i]);
            end
          end
        endcase
        if (picked.size() == 0) begin
          expect_single(ST_EMPTY_RESULT);
        end else begin
          foreach (picked[i]) begin
            r.value = picked[i];
            r.status = ST_MEMBER;
            r.last = (i == picked.size() - 1);
            due_results.push_back(r);
          end
        end
      end
    end
  endfunction

  function automatic void queue_command(logic [1:0] kind, logic sel, logic [31:0] value,
                                        op_e op);
    command_t c;
    c.kind = kind;
    c.sel = sel;
    c.value = value;
    c.op = op;
    command_queue.push_back(c);
    if (kind != KindUnused) counted_commands++;
  endfunction

  function automatic op_e any_op();
    return op_e'($urandom_range(0, 3));
  endfunction

  // Mostly values from a shared pool, so that the two sets overlap and adds repeat.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom();
  endfunction

  function automatic void note_mismatch(string detail);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) $display("%0t ns: %s", $time, detail);
  endfunction

  // Stimulus, reset and the end of the run.
  initial begin
    int fill;
    int pick;
    int target;
    logic sel;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    for (int i = 5; i < PoolSize; i++) value_pool[i] = $urandom();

    // Directed part: an operation before anything is stored, the value extremes,
    // a duplicate, every operation, an ignored kind and the empty result.
    queue_command(KIND_OP, 1'b1, $urandom(), OP_OR);
    queue_command(KIND_CLEAR, 1'b0, $urandom(), any_op());
    queue_command(KIND_ADD, 1'b0, 32'h8000_0000, any_op());
    queue_command(KIND_ADD, 1'b0, 32'h7fff_ffff, any_op());
    queue_command(KIND_ADD, 1'b0, 32'h0000_0000, any_op());
    queue_command(KIND_ADD, 1'b0, 32'hffff_ffff, any_op());
    queue_command(KIND_ADD, 1'b0, 32'h8000_0000, any_op());
    queue_command(KIND_OP, 1'b0, $urandom(), OP_AND);
    queue_command(KIND_ADD, 1'b1, 32'h0000_0000, any_op());
    queue_command(KIND_ADD, 1'b1, 32'h7fff_ffff, any_op());
    queue_command(KIND_ADD, 1'b1, 32'h0000_0005, any_op());
    queue_command(KIND_OP, 1'b1, $urandom(), OP_AND);
    queue_command(KIND_OP, 1'b0, $urandom(), OP_OR);
    queue_command(KIND_OP, 1'b1, $urandom(), OP_A_MINUS_B);
    queue_command(KIND_OP, 1'b0, $urandom(), OP_B_MINUS_A);
    queue_command(KindUnused, 1'b1, $urandom(), any_op());
    queue_command(KIND_CLEAR, 1'b0, $urandom(), any_op());
    queue_command(KIND_ADD, 1'b0, 32'h0000_0000, any_op());
    queue_command(KIND_OP, 1'b1, $urandom(), OP_A_MINUS_B);
    queue_command(KIND_OP, 1'b0, $urandom(), OP_AND);
    queue_command(KIND_OP, 1'b1, $urandom(), OP_B_MINUS_A);
    queue_command(KIND_CLEAR, 1'b1, $urandom(), any_op());
    queue_command(KIND_OP, 1'b0, $urandom(), OP_OR);
    target = counted_commands + RandomCommands;

    // Fill set B to capacity, overflow it, then add a duplicate to the full set.
    queue_command(KIND_CLEAR, 1'b1, $urandom(), any_op());
    for (int i = 0; i <= Capacity; i++) queue_command(KIND_ADD, 1'b1, value_pool[i], any_op());
    queue_command(KIND_ADD, 1'b1, value_pool[0], any_op());
    queue_command(KIND_OP, 1'($urandom_range(0, 1)), $urandom(), OP_OR);
    queue_command(KIND_OP, 1'($urandom_range(0, 1)), $urandom(), OP_B_MINUS_A);

    // Random part: mostly rebuilt sets followed by operations, with some noise.
    while (counted_commands < target) begin
      pick = $urandom_range(0, 99);
      sel = 1'($urandom_range(0, 1));
      if (pick < 30) begin
        fill = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 7);
        queue_command(KIND_CLEAR, sel, $urandom(), any_op());
        for (int i = 0; i < fill; i++) queue_command(KIND_ADD, sel, pick_value(), any_op());
        repeat ($urandom_range(1, 3)) begin
          queue_command(KIND_OP, 1'($urandom_range(0, 1)), $urandom(), any_op());
        end
      end else if (pick < 55) begin
        repeat ($urandom_range(1, 4)) queue_command(KIND_ADD, sel, pick_value(), any_op());
      end else if (pick < 85) begin
        queue_command(KIND_OP, sel, $urandom(), any_op());
      end else if (pick < 93) begin
        queue_command(KIND_CLEAR, sel, $urandom(), any_op());
      end else begin
        queue_command(2'($urandom_range(0, 3)), sel, $urandom(), any_op());
      end
    end
    total_commands = command_queue.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_commands < total_commands || due_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Input driver: presents the next word after the current one is taken,
  // with random idle bursts between words and a payload that changes while idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_gap != 0 && !tail_phase) begin
        in_gap--;
        in_valid_i <= 1'b0;
        kind_i <= 2'($urandom_range(0, 3));
        set_select_i <= 1'($urandom_range(0, 1));
        element_value_i <= $urandom();
        operation_i <= 2'($urandom_range(0, 3));
      end else if (command_queue.size() != 0) begin
        next_command = command_queue.pop_front();
        in_valid_i <= 1'b1;
        kind_i <= next_command.kind;
        set_select_i <= next_command.sel;
        element_value_i <= next_command.value;
        operation_i <= next_command.op;
        if ($urandom_range(0, 39) == 0) in_idle_on = !in_idle_on;
        if (!tail_phase && in_idle_on && $urandom_range(0, 2) == 0) begin
          in_gap = $urandom_range(1, 9);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall: random bursts, switched off now and then and during the tail.
  always @(negedge clk_i) begin
    if (!rst_ni || tail_phase) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (stall_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      if ($urandom_range(0, 199) == 0) stall_on = !stall_on;
    end
  end

  // Monitor: predicts on every accepted input word and checks every accepted result word.
  always @(posedge clk_i) begin
    command_t c;
    result_t want;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        c.kind = kind_i;
        c.sel = set_select_i;
        c.value = element_value_i;
        c.op = op_e'(operation_i);
        apply_command(c);
        accepted_commands++;
        tail_phase = (accepted_commands + TailCommands >= total_commands);
      end
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("unexpected word: value %0d status %0d last %b",
                                  member_value_o, status_o, last_o));
        end else begin
          want = due_results.pop_front();
          if (member_value_o !== want.value || status_o !== want.status ||
              last_o !== want.last) begin
            note_mismatch($sformatf(
                "wrong word: expected value %0d status %s last %b, got value %0d status %0d last %b",
                $signed(want.value), want.status.name(), want.last,
                member_value_o, status_o, last_o));
          end
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved a word for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
